[hw/rtl/ansi_sgr_style_parser_top_macros.svh]
// assertion macros shared by the sgr parser rtl
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef ANSI_SGR_STYLE_PARSER_TOP_MACROS_SVH
`define ANSI_SGR_STYLE_PARSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SGR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// trigger in one cycle implies outcome in the next
`define SGR_ASSERT_NEXT(label, clk, rst_n, trig, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error(msg);
`else
`define SGR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define SGR_ASSERT_NEXT(label, clk, rst_n, trig, outcome, msg)
`endif
`endif

[hw/rtl/ansi_sgr_pkg.sv]
// shared types and constants of the sgr escape parser
// depends on nothing
package ansi_sgr_pkg;

    localparam logic [7:0] ESC_CHAR    = 8'h1b;
    localparam logic [7:0] LBRACKET    = 8'h5b;
    localparam logic [7:0] SEMICOLON   = 8'h3b;
    localparam logic [7:0] FINAL_M     = 8'h6d;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [7:0] PARAM_MAX   = 8'd255;

    // sgr parameter codes understood by the parser
    localparam logic [7:0] SGR_RESET          = 8'd0;
    localparam logic [7:0] SGR_BOLD           = 8'd1;
    localparam logic [7:0] SGR_DIM            = 8'd2;
    localparam logic [7:0] SGR_UNDERLINE      = 8'd4;
    localparam logic [7:0] SGR_REVERSE        = 8'd7;
    localparam logic [7:0] SGR_NORMAL_WEIGHT  = 8'd22;
    localparam logic [7:0] SGR_NO_UNDERLINE   = 8'd24;
    localparam logic [7:0] SGR_NO_REVERSE     = 8'd27;
    localparam logic [7:0] SGR_FG_BASE        = 8'd30;
    localparam logic [7:0] SGR_FG_DEFAULT     = 8'd39;
    localparam logic [7:0] SGR_BG_BASE        = 8'd40;
    localparam logic [7:0] SGR_BG_DEFAULT     = 8'd49;
    localparam logic [7:0] SGR_FG_BRIGHT_BASE = 8'd90;
    localparam logic [7:0] SGR_BG_BRIGHT_BASE = 8'd100;
    // offset of the last colour of a colour group from its base
    localparam logic [7:0] SGR_COLOR_SPAN     = 8'd7;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // work handed from the front to the back for one accepted item
    typedef struct packed {
        logic [1:0] res_count;   // results to emit, 0 to 2
        logic [7:0] byte0;
        logic       byte0_valid; // 0 only for the empty end marker
        logic [7:0] byte1;
        logic       last;        // item closes the text
        logic       apply_en;    // apply code to the style after emitting
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic [2:0] fg;
        logic       fg_set;
        logic [2:0] bg;
        logic       bg_set;
        logic [3:0] attrs;       // bit0 bold, bit1 dim, bit2 underline, bit3 reverse
    } style_t;

endpackage

[hw/rtl/ansi_sgr_if.sv]
// valid/ready channel interfaces for the input and result items
// depends on nothing
interface ansi_sgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ansi_sgr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] fg_color;
    logic       fg_set;
    logic [2:0] bg_color;
    logic       bg_set;
    logic       bold;
    logic       dim;
    logic       underline;
    logic       reverse_video;
    logic       last_of_text;

    modport source (output valid, input ready, output out_byte, output byte_valid,
                    output fg_color, output fg_set, output bg_color, output bg_set,
                    output bold, output dim, output underline, output reverse_video,
                    output last_of_text);
    modport sink (input valid, output ready, input out_byte, input byte_valid,
                  input fg_color, input fg_set, input bg_color, input bg_set,
                  input bold, input dim, input underline, input reverse_video,
                  input last_of_text);
endinterface

[hw/rtl/ansi_sgr_front.sv]
// front end: accepts bytes, tracks escape parsing, builds commands for the queue
// depends on ansi_sgr_pkg and ansi_sgr_in_if
`include "ansi_sgr_style_parser_top_macros.svh"

module ansi_sgr_front
    import ansi_sgr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ansi_sgr_in_if.sink   in_ch,
    input  logic          fifo_full,
    output logic          push,
    output cmd_t          cmd
);

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_SEQ   = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  param_reg, param_next;
    logic        digit_reg, digit_next;
    logic        accept;
    logic [11:0] param_acc;
    cmd_t        cmd_c;

    assign in_ch.ready = !fifo_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // param * 10 + digit, saturated below
    assign param_acc = {1'b0, param_reg, 3'b000} + {3'b000, param_reg, 1'b0}
                     + {8'd0, in_ch.text_byte[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        param_next = param_reg;
        digit_next = digit_reg;
        cmd_c              = '0;
        cmd_c.byte0_valid  = 1'b1;

        unique case (mode_reg)
            MODE_ESC:
            begin
                if (in_ch.text_byte == LBRACKET)
                begin
                    mode_next  = MODE_SEQ;
                    param_next = '0;
                    digit_next = 1'b0;
                end
                else
                begin
                    // held escape goes out as text
                    cmd_c.byte0     = ESC_CHAR;
                    cmd_c.res_count = 2'd1;
                    if (in_ch.text_byte == ESC_CHAR)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        cmd_c.byte1     = in_ch.text_byte;
                        cmd_c.res_count = 2'd2;
                        mode_next       = MODE_PLAIN;
                    end
                end
            end
            MODE_SEQ:
            begin
                if (in_ch.text_byte >= DIGIT_ZERO && in_ch.text_byte <= DIGIT_NINE)
                begin
                    param_next = (param_acc > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                                 : param_acc[7:0];
                    digit_next = 1'b1;
                end
                else if (in_ch.text_byte == SEMICOLON)
                begin
                    cmd_c.apply_en = digit_reg;
                    cmd_c.code     = param_reg;
                    param_next     = '0;
                    digit_next     = 1'b0;
                end
                else if (in_ch.text_byte == FINAL_M)
                begin
                    // empty final parameter acts as a reset code
                    cmd_c.apply_en = 1'b1;
                    cmd_c.code     = digit_reg ? param_reg : 8'd0;
                    param_next     = '0;
                    digit_next     = 1'b0;
                    mode_next      = MODE_PLAIN;
                end
            end
            default:
            begin
                if (in_ch.text_byte == ESC_CHAR)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    cmd_c.byte0     = in_ch.text_byte;
                    cmd_c.res_count = 2'd1;
                    mode_next       = MODE_PLAIN;
                end
            end
        endcase

        if (in_ch.end_of_text)
        begin
            if (mode_next == MODE_ESC)
            begin
                if (cmd_c.res_count == 2'd0)
                begin
                    cmd_c.byte0     = ESC_CHAR;
                    cmd_c.res_count = 2'd1;
                end
                else
                begin
                    cmd_c.byte1     = ESC_CHAR;
                    cmd_c.res_count = 2'd2;
                end
            end
            if (cmd_c.res_count == 2'd0)
            begin
                cmd_c.byte0       = 8'd0;
                cmd_c.byte0_valid = 1'b0;
                cmd_c.res_count   = 2'd1;
            end
            cmd_c.last = 1'b1;
            mode_next  = MODE_PLAIN;
            param_next = '0;
            digit_next = 1'b0;
        end
    end

    assign cmd  = cmd_c;
    assign push = accept && (cmd_c.res_count != 2'd0 || cmd_c.apply_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            param_reg <= '0;
            digit_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            param_reg <= param_next;
            digit_reg <= digit_next;
        end
    end

    `SGR_ASSERT_NEXT(a_end_resets_parser, clk, rst_n, accept && in_ch.end_of_text,
        mode_reg == MODE_PLAIN && param_reg == 8'd0 && !digit_reg,
        "parser not back in plain text after end of text")
    `SGR_ASSERT_ALWAYS(a_mode_reachable, clk, rst_n, mode_reg != 2'd3,
        "parser mode left the reachable set")

endmodule

[hw/rtl/ansi_sgr_fifo.sv]
// short command queue between the parser front and the style back end
// depends on ansi_sgr_pkg
`include "ansi_sgr_style_parser_top_macros.svh"

module ansi_sgr_fifo
    import ansi_sgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t                  store_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SGR_ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(push && full),
        "command pushed into a full queue")
    `SGR_ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !(pop && empty),
        "command popped from an empty queue")

endmodule

[hw/rtl/ansi_sgr_back.sv]
// back end: holds the style, emits results, applies sgr codes
// depends on ansi_sgr_pkg and ansi_sgr_out_if
`include "ansi_sgr_style_parser_top_macros.svh"

module ansi_sgr_back
    import ansi_sgr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cmd_t           head,
    input  logic           empty,
    output logic           pop,
    ansi_sgr_out_if.source out_ch
);

    style_t     style_reg, style_next;
    logic       idx_reg, idx_next;
    logic       out_valid_reg;
    logic       out_load;
    logic       emit;
    logic [7:0] res_byte;
    logic       res_valid;
    logic       res_last;
    logic [7:0] res_byte_reg;
    logic       res_valid_reg;
    logic       res_last_reg;
    style_t     res_style_reg;
    logic [7:0] code_fg;
    logic [7:0] code_bg;
    logic [7:0] code_fg_hi;
    logic [7:0] code_bg_hi;
    style_t     applied;

    assign out_load = !out_valid_reg || out_ch.ready;

    // pick the result to emit from the head command
    always_comb
    begin
        emit      = 1'b0;
        pop       = 1'b0;
        idx_next  = idx_reg;
        res_byte  = head.byte0;
        res_valid = head.byte0_valid;
        res_last  = head.last && (head.res_count == 2'd1);
        if (idx_reg)
        begin
            res_byte  = head.byte1;
            res_valid = 1'b1;
            res_last  = head.last;
        end
        if (!empty)
        begin
            if (head.res_count == 2'd0)
            begin
                pop = 1'b1;
            end
            else if (out_load)
            begin
                emit = 1'b1;
                if ({1'b0, idx_reg} == head.res_count - 2'd1)
                begin
                    pop      = 1'b1;
                    idx_next = 1'b0;
                end
                else
                begin
                    idx_next = 1'b1;
                end
            end
        end
    end

    assign code_fg    = head.code - SGR_FG_BASE;
    assign code_bg    = head.code - SGR_BG_BASE;
    assign code_fg_hi = head.code - SGR_FG_BRIGHT_BASE;
    assign code_bg_hi = head.code - SGR_BG_BRIGHT_BASE;

    // one sgr code on the current style
    always_comb
    begin
        applied = style_reg;
        priority if (head.code == SGR_RESET)
        begin
            applied = '0;
        end
        else if (head.code == SGR_BOLD)
        begin
            applied.attrs[0] = 1'b1;
        end
        else if (head.code == SGR_DIM)
        begin
            applied.attrs[1] = 1'b1;
        end
        else if (head.code == SGR_UNDERLINE)
        begin
            applied.attrs[2] = 1'b1;
        end
        else if (head.code == SGR_REVERSE)
        begin
            applied.attrs[3] = 1'b1;
        end
        else if (head.code == SGR_NORMAL_WEIGHT)
        begin
            applied.attrs[1:0] = 2'b00;
        end
        else if (head.code == SGR_NO_UNDERLINE)
        begin
            applied.attrs[2] = 1'b0;
        end
        else if (head.code == SGR_NO_REVERSE)
        begin
            applied.attrs[3] = 1'b0;
        end
        else if (head.code == SGR_FG_DEFAULT)
        begin
            applied.fg     = 3'd0;
            applied.fg_set = 1'b0;
        end
        else if (head.code == SGR_BG_DEFAULT)
        begin
            applied.bg     = 3'd0;
            applied.bg_set = 1'b0;
        end
        else if (head.code >= SGR_FG_BASE && head.code <= SGR_FG_BASE + SGR_COLOR_SPAN)
        begin
            applied.fg     = code_fg[2:0];
            applied.fg_set = 1'b1;
        end
        else if (head.code >= SGR_BG_BASE && head.code <= SGR_BG_BASE + SGR_COLOR_SPAN)
        begin
            applied.bg     = code_bg[2:0];
            applied.bg_set = 1'b1;
        end
        else if (head.code >= SGR_FG_BRIGHT_BASE
                 && head.code <= SGR_FG_BRIGHT_BASE + SGR_COLOR_SPAN)
        begin
            applied.fg       = code_fg_hi[2:0];
            applied.fg_set   = 1'b1;
            applied.attrs[0] = 1'b1;
        end
        else if (head.code >= SGR_BG_BRIGHT_BASE
                 && head.code <= SGR_BG_BRIGHT_BASE + SGR_COLOR_SPAN)
        begin
            applied.bg     = code_bg_hi[2:0];
            applied.bg_set = 1'b1;
        end
        else
        begin
            applied = style_reg;
        end
    end

    always_comb
    begin
        style_next = style_reg;
        if (pop)
        begin
            if (head.last)
            begin
                style_next = '0;
            end
            else if (head.apply_en)
            begin
                style_next = applied;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg     <= '0;
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            style_reg <= style_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_byte_reg  <= res_valid ? res_byte : 8'd0;
            res_valid_reg <= res_valid;
            res_last_reg  <= res_last;
            res_style_reg <= res_valid ? style_reg : '0;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = res_byte_reg;
    assign out_ch.byte_valid    = res_valid_reg;
    assign out_ch.fg_color      = res_style_reg.fg;
    assign out_ch.fg_set        = res_style_reg.fg_set;
    assign out_ch.bg_color      = res_style_reg.bg;
    assign out_ch.bg_set        = res_style_reg.bg_set;
    assign out_ch.bold          = res_style_reg.attrs[0];
    assign out_ch.dim           = res_style_reg.attrs[1];
    assign out_ch.underline     = res_style_reg.attrs[2];
    assign out_ch.reverse_video = res_style_reg.attrs[3];
    assign out_ch.last_of_text  = res_last_reg;

    `SGR_ASSERT_ALWAYS(a_empty_only_at_end, clk, rst_n,
        !out_valid_reg || res_valid_reg || res_last_reg,
        "result without a byte that does not close the text")
    `SGR_ASSERT_NEXT(a_style_clear_after_end, clk, rst_n, pop && head.last,
        style_reg == '0, "style not cleared after end of text")

endmodule

[hw/rtl/ansi_sgr_style_parser_top.sv]
// top level of the sgr escape parser: front, command queue and back end
// depends on ansi_sgr_pkg, ansi_sgr_if, ansi_sgr_front, ansi_sgr_fifo, ansi_sgr_back

// strips ESC [ params m sequences from a byte stream and tags every visible
// byte with the running style (foreground, background, bold, dim, underline,
// reverse video). one input item per cycle is taken as long as the command
// queue has room; an item that yields two results (a held ESC released
// together with the next byte) holds the result register for both of them,
// so the back end runs behind the input on those items. the queue is four
// commands deep and absorbs short bursts and output stalls. the style and
// the parser return to reset after the item marked end_of_text; an item with
// end_of_text that shows no byte yields one result with byte_valid low and
// last_of_text high. with an empty queue and no output stall, the first
// result of an item is written into the command queue when the item is
// accepted and then into the result register, from which it is offered.
module ansi_sgr_style_parser_top
    import ansi_sgr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ansi_sgr_in_if.sink    in_ch,
    ansi_sgr_out_if.source out_ch
);

    // queue handshake between front and back
    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // parse state and command building
    ansi_sgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .fifo_full (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // decouples parsing from output stalls
    ansi_sgr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .full      (full),
        .empty     (empty)
    );

    // style register and result register
    ansi_sgr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_cmd),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

[sim/tb_top.sv]
// self-checking testbench for the sgr escape parser top level
// depends on ansi_sgr_pkg, ansi_sgr_if and the parser rtl; holds its own style predictor
`timescale 1ns / 1ps

module tb_top
    import ansi_sgr_pkg::*;
();

    // bit positions inside style_t.attrs
    localparam int ATTR_BOLD      = 0;
    localparam int ATTR_DIM       = 1;
    localparam int ATTR_UNDERLINE = 2;
    localparam int ATTR_REVERSE   = 3;

    localparam int TARGET_ITEMS    = 1700;
    localparam int MAX_WAIT        = 18;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_EVERY  = 100;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum logic [1:0] {
        PARSE_TEXT,
        PARSE_ESC_HELD,
        PARSE_SEQ
    } parse_mode_t;

    // one visible byte with its style, or the empty end marker
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        style_t     style;
        logic       last_of_text;
    } styled_byte_t;

    // ------------------------------------------------------------------
    // scoreboard: tracks the parser state and the styled bytes still owed
    // ------------------------------------------------------------------
    class style_scoreboard_t;
        styled_byte_t owed_q[$];
        parse_mode_t  mode;
        logic [7:0]   param_val;
        logic         has_digit;
        style_t       style;
        int           errors;
        int           checked;

        function new();
            errors  = 0;
            checked = 0;
            restart();
        endfunction

        function void restart();
            mode      = PARSE_TEXT;
            param_val = '0;
            has_digit = 1'b0;
            style     = '0;
        endfunction

        function void push_styled(logic [7:0] b, logic visible);
            styled_byte_t r;
            r = '0;
            if (visible)
            begin
                r.out_byte   = b;
                r.byte_valid = 1'b1;
                r.style      = style;
            end
            owed_q = {owed_q, r};
        endfunction

        function void apply_code(int code);
            if (code == SGR_RESET)
                style = '0;
            else if (code == SGR_BOLD)
                style.attrs[ATTR_BOLD] = 1'b1;
            else if (code == SGR_DIM)
                style.attrs[ATTR_DIM] = 1'b1;
            else if (code == SGR_UNDERLINE)
                style.attrs[ATTR_UNDERLINE] = 1'b1;
            else if (code == SGR_REVERSE)
                style.attrs[ATTR_REVERSE] = 1'b1;
            else if (code == SGR_NORMAL_WEIGHT)
            begin
                style.attrs[ATTR_BOLD] = 1'b0;
                style.attrs[ATTR_DIM]  = 1'b0;
            end
            else if (code == SGR_NO_UNDERLINE)
                style.attrs[ATTR_UNDERLINE] = 1'b0;
            else if (code == SGR_NO_REVERSE)
                style.attrs[ATTR_REVERSE] = 1'b0;
            else if (code == SGR_FG_DEFAULT)
            begin
                style.fg     = '0;
                style.fg_set = 1'b0;
            end
            else if (code == SGR_BG_DEFAULT)
            begin
                style.bg     = '0;
                style.bg_set = 1'b0;
            end
            else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_COLOR_SPAN)
            begin
                style.fg     = 3'(code - SGR_FG_BASE);
                style.fg_set = 1'b1;
            end
            else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_COLOR_SPAN)
            begin
                style.bg     = 3'(code - SGR_BG_BASE);
                style.bg_set = 1'b1;
            end
            else if (code >= SGR_FG_BRIGHT_BASE
                     && code <= SGR_FG_BRIGHT_BASE + SGR_COLOR_SPAN)
            begin
                style.fg               = 3'(code - SGR_FG_BRIGHT_BASE);
                style.fg_set           = 1'b1;
                style.attrs[ATTR_BOLD] = 1'b1;
            end
            else if (code >= SGR_BG_BRIGHT_BASE
                     && code <= SGR_BG_BRIGHT_BASE + SGR_COLOR_SPAN)
            begin
                style.bg     = 3'(code - SGR_BG_BRIGHT_BASE);
                style.bg_set = 1'b1;
            end
        endfunction

        function void plain_byte(logic [7:0] b);
            if (b == ESC_CHAR)
                mode = PARSE_ESC_HELD;
            else
                push_styled(b, 1'b1);
        endfunction

        function void sequence_byte(logic [7:0] b);
            int v;
            if (b >= DIGIT_ZERO && b <= DIGIT_NINE)
            begin
                v         = int'(param_val) * 10 + int'(b - DIGIT_ZERO);
                param_val = (v > int'(PARAM_MAX)) ? PARAM_MAX : 8'(v);
                has_digit = 1'b1;
            end
            else if (b == SEMICOLON)
            begin
                if (has_digit)
                    apply_code(int'(param_val));
                param_val = '0;
                has_digit = 1'b0;
            end
            else if (b == FINAL_M)
            begin
                apply_code(has_digit ? int'(param_val) : int'(SGR_RESET));
                param_val = '0;
                has_digit = 1'b0;
                mode      = PARSE_TEXT;
            end
        endfunction

        // called for every accepted input item
        function void note_input(logic [7:0] b, logic eot);
            int before_cnt;
            before_cnt = owed_q.size();
            case (mode)
                PARSE_ESC_HELD:
                begin
                    if (b == LBRACKET)
                    begin
                        mode      = PARSE_SEQ;
                        param_val = '0;
                        has_digit = 1'b0;
                    end
                    else
                    begin
                        push_styled(ESC_CHAR, 1'b1);
                        mode = PARSE_TEXT;
                        plain_byte(b);
                    end
                end
                PARSE_SEQ:
                    sequence_byte(b);
                default:
                begin
                    mode = PARSE_TEXT;
                    plain_byte(b);
                end
            endcase
            if (eot)
            begin
                if (mode == PARSE_ESC_HELD)
                    push_styled(ESC_CHAR, 1'b1);
                if (owed_q.size() == before_cnt)
                    push_styled('0, 1'b0);
                owed_q[owed_q.size() - 1].last_of_text = 1'b1;
                restart();
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
            end
        endfunction

        // called for every accepted result
        function void check_result(styled_byte_t seen);
            styled_byte_t want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing owed, expected none, got byte %0h",
                         $time, seen.out_byte);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            compare_field("out_byte", want.out_byte, seen.out_byte);
            compare_field("byte_valid", want.byte_valid, seen.byte_valid);
            compare_field("fg_color", want.style.fg, seen.style.fg);
            compare_field("fg_set", want.style.fg_set, seen.style.fg_set);
            compare_field("bg_color", want.style.bg, seen.style.bg);
            compare_field("bg_set", want.style.bg_set, seen.style.bg_set);
            compare_field("bold", want.style.attrs[ATTR_BOLD], seen.style.attrs[ATTR_BOLD]);
            compare_field("dim", want.style.attrs[ATTR_DIM], seen.style.attrs[ATTR_DIM]);
            compare_field("underline", want.style.attrs[ATTR_UNDERLINE],
                          seen.style.attrs[ATTR_UNDERLINE]);
            compare_field("reverse_video", want.style.attrs[ATTR_REVERSE],
                          seen.style.attrs[ATTR_REVERSE]);
            compare_field("last_of_text", want.last_of_text, seen.last_of_text);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ansi_sgr_in_if  in_ch();
    ansi_sgr_out_if out_ch();

    ansi_sgr_style_parser_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    style_scoreboard_t sb = new();

    int items_sent;
    int texts_sent;
    int hold_offs;
    int stall_cycles;

    // the plain codes, in no particular order
    int simple_codes[10] = '{SGR_RESET, SGR_BOLD, SGR_DIM, SGR_UNDERLINE, SGR_REVERSE,
                             SGR_NORMAL_WEIGHT, SGR_NO_UNDERLINE, SGR_NO_REVERSE,
                             SGR_FG_DEFAULT, SGR_BG_DEFAULT};

    // the text under construction
    logic [7:0] text_q[$];

    // ------------------------------------------------------------------
    // monitor: note inputs first, then check results, both on the same edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        styled_byte_t seen;
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.text_byte, in_ch.end_of_text);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen                          = '0;
            seen.out_byte                 = out_ch.out_byte;
            seen.byte_valid               = out_ch.byte_valid;
            seen.style.fg                 = out_ch.fg_color;
            seen.style.fg_set             = out_ch.fg_set;
            seen.style.bg                 = out_ch.bg_color;
            seen.style.bg_set             = out_ch.bg_set;
            seen.style.attrs[ATTR_BOLD]      = out_ch.bold;
            seen.style.attrs[ATTR_DIM]       = out_ch.dim;
            seen.style.attrs[ATTR_UNDERLINE] = out_ch.underline;
            seen.style.attrs[ATTR_REVERSE]   = out_ch.reverse_video;
            seen.last_of_text             = out_ch.last_of_text;
            sb.check_result(seen);
        end
    end

    // watchdog: too long without any handshake on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still owed",
                     $time, stall_cycles, sb.owed_q.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // result side: random stalls, quiet stretches and a periodic long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        int taken;
        bit quiet;
        out_ch.ready <= 1'b0;
        taken = 0;
        quiet = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // redraw the stall profile every few dozen results
            if (taken % 32 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
            taken++;
            // long hold-off so the command queue fills and the input stalls
            if (taken % HOLD_OFF_EVERY == 0)
            begin
                out_ch.ready <= 1'b0;
                hold_offs++;
                repeat ($urandom_range(300, 400)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side: drivers and text builders
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eot, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // sends text_q with end_of_text on its last byte
    task automatic send_text();
        bit no_gap;
        no_gap = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < text_q.size(); i++)
            send_item(text_q[i], i == text_q.size() - 1, no_gap);
        items_sent += text_q.size();
        texts_sent++;
    endtask

    // appends one byte to the text under construction
    function automatic void add_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void add_number(int n);
        string digits;
        digits = $sformatf("%0d", n);
        for (int i = 0; i < digits.len(); i++)
            add_byte(digits[i]);
    endfunction

    // a parameter value: known codes, arbitrary values up to 255 and out-of-range numbers
    function automatic int pick_code();
        case ($urandom_range(0, 7))
            0: return simple_codes[$urandom_range(0, 9)];
            1: return SGR_FG_BASE + $urandom_range(0, 7);
            2: return SGR_BG_BASE + $urandom_range(0, 7);
            3: return SGR_FG_BRIGHT_BASE + $urandom_range(0, 7);
            4: return SGR_BG_BRIGHT_BASE + $urandom_range(0, 7);
            5: return $urandom_range(0, 255);
            6: return $urandom_range(256, 99999);
            default: return simple_codes[$urandom_range(0, 9)];
        endcase
    endfunction

    // a byte that a sequence ignores
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= DIGIT_ZERO && b <= DIGIT_NINE) || b == SEMICOLON || b == FINAL_M);
        return b;
    endfunction

    function automatic void add_plain();
        if ($urandom_range(0, 3) != 0)
            add_byte(8'($urandom_range(8'h20, 8'h7e)));
        else
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_sequence(bit with_junk, bit terminate);
        int n;
        add_byte(ESC_CHAR);
        add_byte(LBRACKET);
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0)
                add_byte(SEMICOLON);
            if ($urandom_range(0, 7) != 0)
                add_number(pick_code());
            if (with_junk && $urandom_range(0, 2) == 0)
                add_byte(junk_byte());
        end
        // trailing semicolon leaves an empty final parameter
        if ($urandom_range(0, 5) == 0)
            add_byte(SEMICOLON);
        if (terminate)
            add_byte(FINAL_M);
    endfunction

    // one random text, mostly well-formed sequences around visible bytes
    function automatic void build_text();
        int pieces;
        int r;
        text_q.delete();
        pieces = $urandom_range(1, 10);
        for (int p = 0; p < pieces; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add_plain();
            else if (r < 78)
                add_sequence(1'b0, 1'b1);
            else if (r < 86)
            begin
                // stray escape: anything but a bracket follows
                add_byte(ESC_CHAR);
                do
                    r = $urandom_range(0, 255);
                while (r == LBRACKET);
                add_byte(8'(r));
            end
            else if (r < 93)
                add_sequence(1'b1, 1'b1);
            else
                repeat ($urandom_range(3, 6)) add_plain();
        end
        // occasionally end on a lone escape or inside a sequence
        r = $urandom_range(0, 19);
        if (r == 0)
            add_byte(ESC_CHAR);
        else if (r == 1)
            add_sequence(1'b0, 1'b0);
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid       <= 1'b0;
        in_ch.text_byte   <= '0;
        in_ch.end_of_text <= 1'b0;
        items_sent = 0;
        texts_sent = 0;
        hold_offs  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme byte values as plain text
        text_q = '{8'h00, 8'hff};
        send_text();
        // saturated parameter, escape inside a sequence, empty parameter, then bold
        text_q = '{ESC_CHAR, LBRACKET, "9", ESC_CHAR, "9", "9", SEMICOLON, SEMICOLON,
                   "1", FINAL_M, "A"};
        send_text();
        // escape without bracket, then an escape as the last byte
        text_q = '{ESC_CHAR, "X", ESC_CHAR};
        send_text();
        // cut-off sequence: nothing visible, only the end marker
        text_q = '{ESC_CHAR, LBRACKET, "3"};
        send_text();
        // underline then an empty final parameter which resets the style
        text_q = '{ESC_CHAR, LBRACKET, "4", SEMICOLON, FINAL_M, "C"};
        send_text();

        // random texts until the item budget is spent
        while (items_sent < TARGET_ITEMS)
        begin
            build_text();
            send_text();
        end
        in_ch.valid <= 1'b0;
        // let the monitor note the last accepted item before looking at the queue
        @(posedge clk);

        // drain, then give the block a few more cycles to show any extra result
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d texts, %0d items in, %0d results checked, %0d output hold-offs",
                 texts_sent, items_sent, sb.checked, hold_offs);
        $display("covered all sgr code groups, saturated and empty parameters, stray and %s",
                 "trailing escapes, cut-off sequences");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[ansi_sgr_style_parser_top.f]
+incdir+hw/rtl
hw/rtl/ansi_sgr_pkg.sv
hw/rtl/ansi_sgr_if.sv
hw/rtl/ansi_sgr_front.sv
hw/rtl/ansi_sgr_fifo.sv
hw/rtl/ansi_sgr_back.sv
hw/rtl/ansi_sgr_style_parser_top.sv
sim/tb_top.sv
